FILE: rtl/core/pdfq_pkg.sv
// Shared types and constants for the per-device FIFO service queues.
// Holds the request, result, command and entry formats shared by the modules.
// Depends on nothing.
package pdfq_pkg;

	localparam int DEVICE_COUNT = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int STORE_SIZE = DEVICE_COUNT * QUEUE_DEPTH;

	localparam int DEV_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
	localparam int QIDX_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;

	localparam logic [3:0] CFG_RESET = 4'd8;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_COMPLETE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;

	typedef struct packed {
		logic        op;
		logic [3:0]  device;
		logic [15:0] pid;
		logic [7:0]  priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        finished_valid;
		logic [15:0] finished_pid;
		logic [7:0]  finished_priority;
		logic        serving_valid;
		logic [15:0] serving_pid;
	} rsp_t;

	// Layout of a stored process: priority above pid.
	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] pid;
	} entry_t;

	// A classified request as it waits between front and back.
	typedef struct packed {
		logic             bad;
		logic             op;
		logic [DEV_W-1:0] dev_idx;
		entry_t           entry;
	} cmd_t;

endpackage

FILE: rtl/core/pdfq_front.sv
// Front end: accepts requests, holds the device-count register, checks the
// device range and queues classified commands for the back end.
// Depends on pdfq_pkg.
module pdfq_front import pdfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  req_t       req,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data,
	output logic       cmd_valid,
	input  logic       cmd_take,
	output cmd_t       cmd
);

	logic [3:0] cfg_q;
	cmd_t       cmd_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	logic [3:0] dev_m1;
	cmd_t       new_cmd;

	assign cfg_ready = 1'b1;
	assign full = (count_q == 2'd2);
	assign accept = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = cmd_q[rd_ptr_q];
	assign dev_m1 = req.device - 4'd1;

	// A device number is rejected when it is zero or above either the
	// register or the number of devices built.
	always_comb begin
		new_cmd.bad = (req.device == 4'd0) || (int'(req.device) > int'(cfg_q))
			|| (int'(req.device) > DEVICE_COUNT);
		new_cmd.op = req.op;
		new_cmd.dev_idx = DEV_W'(dev_m1);
		new_cmd.entry.prio = req.priority_req;
		new_cmd.entry.pid = req.pid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (cfg_valid) begin
				cfg_q <= cfg_data;
			end
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({accept, cmd_take})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

FILE: rtl/core/pdfq_back.sv
// Back end: per-device service slots, queue pointers and the wait store.
// Executes one command at a time and hands each result to the result queue.
// Depends on pdfq_pkg.
module pdfq_back import pdfq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_take,
	input  logic rsp_full,
	output logic rsp_push,
	output rsp_t rsp_item
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic              state_q;
	logic [QIDX_W-1:0] head_q [DEVICE_COUNT];
	logic [QCNT_W-1:0] count_q [DEVICE_COUNT];
	logic              busy_q [DEVICE_COUNT];
	entry_t            slot_q [DEVICE_COUNT];
	entry_t            mem [STORE_SIZE];
	entry_t            rd_q;
	entry_t            fin_q;
	logic [DEV_W-1:0]  cur_dev_q;
	logic [QIDX_W-1:0] cur_head_q;
	logic [QCNT_W-1:0] cur_count_q;

	logic [QIDX_W-1:0] head;
	logic [QCNT_W-1:0] cnt;
	logic              busy;
	entry_t            slot;
	logic [QCNT_W:0]   tail_sum;
	logic [QIDX_W-1:0] tail;
	logic [QIDX_W-1:0] head_next;
	logic [ADDR_W-1:0] dev_base;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic              do_fill;
	logic              do_append;
	logic              do_release;
	logic              do_promote;

	always_comb begin
		head = head_q[cmd.dev_idx];
		cnt = count_q[cmd.dev_idx];
		busy = busy_q[cmd.dev_idx];
		slot = slot_q[cmd.dev_idx];

		tail_sum = (QCNT_W+1)'(head) + (QCNT_W+1)'(cnt);
		if (tail_sum >= (QCNT_W+1)'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - (QCNT_W+1)'(QUEUE_DEPTH);
		end
		tail = QIDX_W'(tail_sum);
		head_next = (cur_head_q == QIDX_W'(QUEUE_DEPTH - 1)) ? '0
			: cur_head_q + QIDX_W'(1);

		dev_base = ADDR_W'(cmd.dev_idx) * ADDR_W'(QUEUE_DEPTH);
		waddr = dev_base + ADDR_W'(tail);
		raddr = dev_base + ADDR_W'(head);

		cmd_take = (state_q == ST_IDLE) && cmd_valid && !rsp_full;
		do_fill = cmd_take && !cmd.bad && (cmd.op == OP_ADD) && !busy;
		do_append = cmd_take && !cmd.bad && (cmd.op == OP_ADD) && busy
			&& (cnt < QCNT_W'(QUEUE_DEPTH));
		do_release = cmd_take && !cmd.bad && (cmd.op == OP_COMPLETE) && busy
			&& (cnt == '0);
		do_promote = cmd_take && !cmd.bad && (cmd.op == OP_COMPLETE) && busy
			&& (cnt != '0);

		rsp_item = '0;
		rsp_push = 1'b0;
		if (state_q == ST_READ) begin
			// The queue head has arrived from the store and moves into service.
			rsp_push = 1'b1;
			rsp_item.status = STATUS_OK;
			rsp_item.finished_valid = 1'b1;
			rsp_item.finished_pid = fin_q.pid;
			rsp_item.finished_priority = fin_q.prio;
			rsp_item.serving_valid = 1'b1;
			rsp_item.serving_pid = rd_q.pid;
		end else if (cmd_take && !do_promote) begin
			rsp_push = 1'b1;
			if (cmd.bad) begin
				rsp_item.status = STATUS_RANGE;
			end else if (cmd.op == OP_ADD) begin
				rsp_item.status = (do_fill || do_append) ? STATUS_OK : STATUS_FULL;
				rsp_item.serving_valid = 1'b1;
				rsp_item.serving_pid = do_fill ? cmd.entry.pid : slot.pid;
			end else if (busy) begin
				rsp_item.finished_valid = 1'b1;
				rsp_item.finished_pid = slot.pid;
				rsp_item.finished_priority = slot.prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < DEVICE_COUNT; i++) begin
				head_q[i] <= '0;
				count_q[i] <= '0;
				busy_q[i] <= 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (do_promote) begin
						state_q <= ST_READ;
					end
					if (do_fill) begin
						busy_q[cmd.dev_idx] <= 1'b1;
					end
					if (do_append) begin
						count_q[cmd.dev_idx] <= cnt + QCNT_W'(1);
					end
					if (do_release) begin
						busy_q[cmd.dev_idx] <= 1'b0;
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					head_q[cur_dev_q] <= head_next;
					count_q[cur_dev_q] <= cur_count_q - QCNT_W'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_fill) begin
			slot_q[cmd.dev_idx] <= cmd.entry;
		end
		if (state_q == ST_READ) begin
			slot_q[cur_dev_q] <= rd_q;
		end
		if (do_promote) begin
			fin_q <= slot;
			cur_dev_q <= cmd.dev_idx;
			cur_head_q <= head;
			cur_count_q <= cnt;
		end
	end

	// Wait store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (do_append) begin
			mem[waddr] <= cmd.entry;
		end
		rd_q <= mem[raddr];
	end

endmodule

FILE: rtl/core/pdfq_rsp_fifo.sv
// Two-entry result queue between the back end and the result ports.
// Lets the back end finish an item while an earlier result waits.
// Depends on pdfq_pkg.
module pdfq_rsp_fifo import pdfq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rsp_t wr_item,
	output logic wr_full,
	input  logic pop,
	output logic empty,
	output rsp_t rsp
);

	rsp_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       take;

	assign wr_full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign take = pop && !empty;
	assign rsp = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, take})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

FILE: rtl/core/per_device_fifo_service_queues.sv
// Top level of the per-device FIFO service queues.
// Joins front end, back end and result queue; depends on pdfq_pkg.
//
//   channel   signals                       transfer when
//   request   push, full, req               push && !full
//   result    empty, pop, rsp               pop && !empty
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready
//
// The back end executes one command per cycle while the result queue has
// room; a complete that promotes a waiting entry adds a read state for
// the registered read of the wait store. On its way to the result ports
// a result passes the command queue and then the result queue.
// Reset clears all slots and queues; the wait store itself is not cleared.
// A full result queue stalls the back end, and the two-entry command queue
// then fills and raises full.
module per_device_fifo_service_queues import pdfq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  req_t       req,
	output logic       empty,
	input  logic       pop,
	output rsp_t       rsp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	logic cmd_valid;
	logic cmd_take;
	cmd_t cmd;
	logic rsp_full;
	logic rsp_push;
	rsp_t rsp_item;

	pdfq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd       (cmd)
	);

	pdfq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push),
		.rsp_item  (rsp_item)
	);

	pdfq_rsp_fifo u_rsp_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rsp_push),
		.wr_item (rsp_item),
		.wr_full (rsp_full),
		.pop     (pop),
		.empty   (empty),
		.rsp     (rsp)
	);

endmodule

FILE: rtl/core/pdfq_checker.sv
// Port-level checks on the result channel of the service queues.
// Bound to per_device_fifo_service_queues; depends on pdfq_pkg.
module pdfq_checker import pdfq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input rsp_t rsp
);

	// A rejected device number reports no process in service and none released.
	a_range_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == STATUS_RANGE) |->
		(!rsp.serving_valid && !rsp.finished_valid && rsp.serving_pid == 16'd0))
		else $error("range error result carries process data");

	// A dropped add only happens when the slot is occupied.
	a_full_serving: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status == STATUS_FULL) |-> rsp.serving_valid)
		else $error("queue full reported on an idle device");

	// Released process fields are zero when nothing was released.
	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !rsp.finished_valid) |->
		(rsp.finished_pid == 16'd0 && rsp.finished_priority == 8'd0))
		else $error("finished fields set without a release");

	// A result that is not taken stays as it is.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(rsp)))
		else $error("waiting result changed before its transfer");

endmodule

bind per_device_fifo_service_queues pdfq_checker u_pdfq_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.rsp    (rsp)
);
